/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL. Define ASSERT_OFF to drop
// every assertion from the build.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* rtl/core/bdc_pkg.sv */
// ----------------------------------------------------------------------------
// Button debounce classifier package
// Shared types and constants: register indexes, duration set, event flags.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned TICK_W    = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVELS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DEBOUNCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_DEBOUNCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_CLICK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP     = 3'd5;

  localparam int unsigned EVT_COUNT = 6;

  typedef struct packed {
    logic [DUR_W-1:0] press;
    logic [DUR_W-1:0] release_db;
    logic [DUR_W-1:0] hold;
    logic [DUR_W-1:0] single;
    logic [DUR_W-1:0] gap;
  } dur_t;

  localparam dur_t DUR_RESET = '{
    press:      16'd50,
    release_db: 16'd50,
    hold:       16'd1000,
    single:     16'd300,
    gap:        16'd300
  };

  // Event flags of one button for one tick; pressed sits in bit 0.
  typedef struct packed {
    logic hold_end;
    logic hold_start;
    logic dbl;
    logic sgl;
    logic rel;
    logic prs;
  } evt_t;

endpackage

`default_nettype wire

/* rtl/core/bdc_state_mem.sv */
// ----------------------------------------------------------------------------
// Per-button state memory
// Synchronous one-read one-write memory with a registered read port,
// per-entry valid bits for the reset state and write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bdc_state_mem #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 98,
  parameter logic [WIDTH-1:0] RESET_WORD = '0,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld_q;
  logic             fwd_q;
  logic [WIDTH-1:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
        // The array returns old data when the same entry is written at this edge.
        fwd_q    <= we_i && (waddr_i == raddr_i);
      end
    end
  end

  // An entry never written since reset reads as the reset state.
  assign rdata_o = fwd_q ? fwd_data_q : (rd_vld_q ? rd_q : RESET_WORD);

  `ASSERT_PROP(a_fwd_same_entry, clk_i, rst_ni,
    (re_i && we_i && (waddr_i == raddr_i)) |=> (rdata_o == $past(wdata_i)),
    "read of an entry written at the same edge did not return the new word")

endmodule

`default_nettype wire

/* rtl/core/bdc_button_eval.sv */
// ----------------------------------------------------------------------------
// Button state update
// Advances one button's countdowns by one tick, handles expirations and pin
// edges, and returns the new state word with this tick's event flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_button_eval #(
  parameter int unsigned TIMER_WIDTH = 16,
  parameter int unsigned ENT_W       = 2 + 4 * TIMER_WIDTH + bdc_pkg::TICK_W
) (
  input  wire logic [ENT_W-1:0]            ent_i,
  input  wire logic                        pin_i,
  input  wire logic                        active_i,
  input  wire logic [bdc_pkg::TICK_W-1:0]  tick_i,
  input  wire bdc_pkg::dur_t               dur_i,
  output logic      [ENT_W-1:0]            ent_o,
  output bdc_pkg::evt_t                    evt_o
);

  localparam logic [31:0] TMR_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

  typedef struct packed {
    logic                       last_lvl;
    logic                       released;
    logic [TIMER_WIDTH-1:0]     press_cd;
    logic [TIMER_WIDTH-1:0]     rel_cd;
    logic [TIMER_WIDTH-1:0]     hold_cd;
    logic [TIMER_WIDTH-1:0]     single_cd;
    logic [bdc_pkg::TICK_W-1:0] latest;
  } ent_t;

  // A duration of zero behaves as one; long durations saturate to the timer.
  function automatic logic [TIMER_WIDTH-1:0] load_val(input logic [bdc_pkg::DUR_W-1:0] ticks);
    logic [31:0] t;
    t = 32'(ticks);
    if (t == 32'd0) begin
      t = 32'd1;
    end
    if (t > TMR_MAX) begin
      t = TMR_MAX;
    end
    return t[TIMER_WIDTH-1:0];
  endfunction

  ent_t                       cur;
  ent_t                       nxt;
  logic                       hold_x;
  logic                       single_x;
  logic                       press_x;
  logic                       rel_x;
  logic [bdc_pkg::TICK_W-1:0] since_rel;

  assign cur       = ent_t'(ent_i);
  assign since_rel = tick_i - cur.latest;
  assign hold_x    = (cur.hold_cd == TIMER_WIDTH'(1));
  assign single_x  = (cur.single_cd == TIMER_WIDTH'(1));
  assign press_x   = (cur.press_cd == TIMER_WIDTH'(1));
  assign rel_x     = (cur.rel_cd == TIMER_WIDTH'(1));

  always_comb begin
    nxt   = cur;
    evt_o = '0;

    if (cur.hold_cd != '0) begin
      nxt.hold_cd = cur.hold_cd - TIMER_WIDTH'(1);
    end
    if (cur.single_cd != '0) begin
      nxt.single_cd = cur.single_cd - TIMER_WIDTH'(1);
    end
    if (cur.press_cd != '0) begin
      nxt.press_cd = cur.press_cd - TIMER_WIDTH'(1);
    end
    if (cur.rel_cd != '0) begin
      nxt.rel_cd = cur.rel_cd - TIMER_WIDTH'(1);
    end

    evt_o.hold_start = hold_x;
    evt_o.sgl        = single_x;

    if (press_x) begin
      evt_o.prs     = 1'b1;
      nxt.released  = 1'b0;
      nxt.single_cd = '0;
      nxt.hold_cd   = load_val(dur_i.hold);
    end

    if (rel_x) begin
      evt_o.rel    = 1'b1;
      nxt.released = 1'b1;
      nxt.latest   = tick_i;
      if (nxt.hold_cd != '0) begin
        nxt.hold_cd = '0;
        // Gap between this release and the one before it.
        if (since_rel < 32'(dur_i.gap)) begin
          evt_o.dbl = 1'b1;
        end else begin
          nxt.single_cd = load_val(dur_i.single);
        end
      end else begin
        evt_o.hold_end = 1'b1;
      end
    end

    if (pin_i != cur.last_lvl) begin
      nxt.last_lvl = pin_i;
      if (pin_i == active_i) begin
        if (nxt.press_cd == '0) begin
          nxt.rel_cd = '0;
          if (nxt.released) begin
            nxt.press_cd = load_val(dur_i.press);
          end
        end
      end else if (nxt.rel_cd == '0) begin
        nxt.press_cd = '0;
        nxt.rel_cd   = load_val(dur_i.release_db);
      end
    end
  end

  assign ent_o = ENT_W'(nxt);

endmodule

`default_nettype wire

/* rtl/core/button_debounce_click_classifier_unit.sv */
// ----------------------------------------------------------------------------
// Button debounce and click classifier
// Debounces BUTTON_COUNT buttons and reports presses, releases, single and
// double clicks and press-and-hold start and end, one result word per tick.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents (low bits first)
//  s_axis    in         pin_levels
//  m_axis    out        pressed, released, single, double, hold start, hold end
//  cfg       in         register index, register value
//
//  Each button's state word goes once per tick through the read-modify-write
//  path of the state memory, one button per cycle while the update stage is
//  not stalled. The next tick is taken in the cycle its predecessor's last
//  button is read; the result word is registered when the last button is
//  written back. Reset clears control and the memory's valid bits, so no
//  clearing pass is needed. A full output register stalls the last button's
//  write-back, which holds the pipeline and the input.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module button_debounce_click_classifier_unit #(
  parameter int unsigned BUTTON_COUNT = 4,
  parameter int unsigned TIMER_WIDTH  = 16,
  localparam int unsigned IN_W  = ((BUTTON_COUNT + 7) / 8) * 8,
  localparam int unsigned EVT_W = bdc_pkg::EVT_COUNT * BUTTON_COUNT,
  localparam int unsigned OUT_W = ((EVT_W + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // pin_levels
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [IN_W-1:0]               s_axis_tdata,
  // pressed_events, released_events, single_clicks, double_clicks,
  // holds_started, holds_ended
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [OUT_W-1:0]              m_axis_tdata,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bdc_pkg::DUR_W-1:0]     cfg_data_i
);

  localparam int unsigned BW    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int unsigned ENT_W = 2 + 4 * TIMER_WIDTH + bdc_pkg::TICK_W;
  localparam logic [BW-1:0] LAST_BTN = BW'(BUTTON_COUNT - 1);
  // Reset state: pin high, the inactive level at reset; button released, timers idle.
  localparam logic [ENT_W-1:0] RESET_WORD = {2'b11, {(ENT_W - 2){1'b0}}};

  // Configuration registers.
  logic [BUTTON_COUNT-1:0] active_q;
  bdc_pkg::dur_t           dur_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      dur_q    <= bdc_pkg::DUR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bdc_pkg::CFG_ACTIVE_LEVELS:  active_q         <= cfg_data_i[BUTTON_COUNT-1:0];
        bdc_pkg::CFG_PRESS_DEBOUNCE: dur_q.press      <= cfg_data_i;
        bdc_pkg::CFG_REL_DEBOUNCE:   dur_q.release_db <= cfg_data_i;
        bdc_pkg::CFG_HOLD:           dur_q.hold       <= cfg_data_i;
        bdc_pkg::CFG_SINGLE_CLICK:   dur_q.single     <= cfg_data_i;
        bdc_pkg::CFG_DOUBLE_GAP:     dur_q.gap        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Issue stage: walks the buttons of the current tick and reads their state.
  logic                        s1_busy_q;
  logic [BW-1:0]               s1_btn_q;
  logic [BUTTON_COUNT-1:0]     s1_pins_q;
  logic [bdc_pkg::TICK_W-1:0]  s1_tick_q;
  logic [bdc_pkg::TICK_W-1:0]  tick_cnt_q;
  logic                        s1_last;
  logic                        s1_adv;
  logic                        in_fire;

  // Update stage: state word arrives from memory, is updated and written back.
  logic                        s2_valid_q;
  logic [BW-1:0]               s2_btn_q;
  logic                        s2_pin_q;
  logic                        s2_last_q;
  logic [bdc_pkg::TICK_W-1:0]  s2_tick_q;
  logic                        s2_ready;
  logic                        s2_fire;

  logic                        out_valid_q;
  logic [OUT_W-1:0]            out_data_q;
  logic                        out_free;

  logic [bdc_pkg::EVT_COUNT-1:0][BUTTON_COUNT-1:0] acc_q;
  logic [bdc_pkg::EVT_COUNT-1:0][BUTTON_COUNT-1:0] acc_nxt;

  logic [ENT_W-1:0]            rd_ent;
  logic [ENT_W-1:0]            wr_ent;
  bdc_pkg::evt_t               evt;
  logic [bdc_pkg::EVT_COUNT-1:0] evt_bits;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s2_fire       = s2_valid_q && (!s2_last_q || out_free);
  assign s2_ready      = !s2_valid_q || s2_fire;
  assign s1_last       = (s1_btn_q == LAST_BTN);
  assign s1_adv        = s1_busy_q && s2_ready;
  assign s_axis_tready = !s1_busy_q || (s1_adv && s1_last);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_busy_q  <= 1'b0;
      s1_btn_q   <= '0;
      tick_cnt_q <= '0;
    end else if (in_fire) begin
      s1_busy_q  <= 1'b1;
      s1_btn_q   <= '0;
      tick_cnt_q <= tick_cnt_q + bdc_pkg::TICK_W'(1);
    end else if (s1_adv) begin
      if (s1_last) begin
        s1_busy_q <= 1'b0;
      end else begin
        s1_btn_q <= s1_btn_q + BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pins_q <= s_axis_tdata[BUTTON_COUNT-1:0];
      s1_tick_q <= tick_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_btn_q  <= s1_btn_q;
      s2_pin_q  <= s1_pins_q[s1_btn_q];
      s2_last_q <= s1_last;
      s2_tick_q <= s1_tick_q;
    end
  end

  bdc_state_mem #(
    .DEPTH      (BUTTON_COUNT),
    .WIDTH      (ENT_W),
    .RESET_WORD (RESET_WORD)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (s1_adv),
    .raddr_i (s1_btn_q),
    .we_i    (s2_fire),
    .waddr_i (s2_btn_q),
    .wdata_i (wr_ent),
    .rdata_o (rd_ent)
  );

  bdc_button_eval #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .ENT_W       (ENT_W)
  ) u_eval (
    .ent_i    (rd_ent),
    .pin_i    (s2_pin_q),
    .active_i (active_q[s2_btn_q]),
    .tick_i   (s2_tick_q),
    .dur_i    (dur_q),
    .ent_o    (wr_ent),
    .evt_o    (evt)
  );

  assign evt_bits = evt;

  always_comb begin
    acc_nxt = acc_q;
    for (int k = 0; k < bdc_pkg::EVT_COUNT; k++) begin
      acc_nxt[k][s2_btn_q] = evt_bits[k];
    end
  end

  // Event word of the tick in flight, collected one button at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (s2_fire) begin
      acc_q <= s2_last_q ? '0 : acc_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire && s2_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && s2_last_q) begin
      out_data_q <= OUT_W'(acc_nxt);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `ASSERT_PROP(a_stall_only_on_full_output, clk_i, rst_ni,
    (s2_valid_q && !s2_fire) |-> (s2_last_q && out_valid_q && !m_axis_tready),
    "update stage stalled without a full output register")

  `ASSERT_PROP(a_accept_only_at_tick_end, clk_i, rst_ni,
    (in_fire && s1_busy_q) |-> (s1_adv && s1_last),
    "new word accepted before the current tick issued all buttons")

  `ASSERT_NEVER(a_no_overwrite_pending, clk_i, rst_ni,
    s2_fire && s2_last_q && out_valid_q && !m_axis_tready,
    "result word overwrote a word not yet taken")

endmodule

`default_nettype wire

/* test/bdc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Click classifier scoreboard
// Watches the tick, result and register channels of the classifier, keeps its
// own copy of the per-button debounce, hold and click timers, predicts every
// result word and compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
module bdc_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tick_valid_i,
  input  wire logic                          tick_ready_i,
  input  wire logic [7:0]                    tick_data_i,   // pin_levels, zero pad
  input  wire logic                          word_valid_i,
  input  wire logic                          word_ready_i,
  input  wire logic [23:0]                   word_data_i,   // pressed, released, single,
                                                            // double, hold start, hold end
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_i,
  input  wire logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bdc_pkg::DUR_W-1:0]     cfg_data_i,
  output int                                 fails_o,
  output int                                 pending_o
);

  localparam int BUTTONS = 4;

  // Field order matches the result word: pressed events in the lowest bits.
  typedef struct packed {
    logic [3:0] hold_end;
    logic [3:0] hold_start;
    logic [3:0] dbl;
    logic [3:0] sgl;
    logic [3:0] rel;
    logic [3:0] prs;
  } tick_flags_t;

  logic [3:0]  active_lvl;
  logic [15:0] press_db, rel_db, hold_len, single_len, gap_len;

  logic [3:0]  last_lvl;
  logic [3:0]  released;
  logic [15:0] press_cd  [BUTTONS];
  logic [15:0] rel_cd    [BUTTONS];
  logic [15:0] hold_cd   [BUTTONS];
  logic [15:0] single_cd [BUTTONS];
  logic [31:0] tick_now;
  logic [31:0] rel_at      [BUTTONS];
  logic [31:0] prev_rel_at [BUTTONS];

  tick_flags_t flags_q [$];

  // A programmed duration of zero behaves as one tick.
  function automatic logic [15:0] load_len(input logic [15:0] d);
    return (d == '0) ? 16'd1 : d;
  endfunction

  function automatic tick_flags_t classify_tick(input logic [3:0] pins);
    tick_flags_t f;
    logic hx, sx, px, rx;
    f = '0;
    for (int b = 0; b < BUTTONS; b++) begin
      hx = (hold_cd[b] == 16'd1);
      sx = (single_cd[b] == 16'd1);
      px = (press_cd[b] == 16'd1);
      rx = (rel_cd[b] == 16'd1);
      if (hold_cd[b] != '0) hold_cd[b] -= 16'd1;
      if (single_cd[b] != '0) single_cd[b] -= 16'd1;
      if (press_cd[b] != '0) press_cd[b] -= 16'd1;
      if (rel_cd[b] != '0) rel_cd[b] -= 16'd1;

      if (hx) f.hold_start[b] = 1'b1;
      if (sx) f.sgl[b] = 1'b1;
      if (px) begin
        f.prs[b] = 1'b1;
        released[b] = 1'b0;
        single_cd[b] = '0;
        hold_cd[b] = load_len(hold_len);
      end
      if (rx) begin
        f.rel[b] = 1'b1;
        released[b] = 1'b1;
        prev_rel_at[b] = rel_at[b];
        rel_at[b] = tick_now;
        // A release while the hold is still pending is a click; one after
        // the hold fired only ends the hold.
        if (hold_cd[b] != '0) begin
          hold_cd[b] = '0;
          if ((rel_at[b] - prev_rel_at[b]) < {16'd0, gap_len}) begin
            f.dbl[b] = 1'b1;
          end else begin
            single_cd[b] = load_len(single_len);
          end
        end else begin
          f.hold_end[b] = 1'b1;
        end
      end

      if (pins[b] != last_lvl[b]) begin
        last_lvl[b] = pins[b];
        if (pins[b] == active_lvl[b]) begin
          if (press_cd[b] == '0) begin
            rel_cd[b] = '0;
            if (released[b]) press_cd[b] = load_len(press_db);
          end
        end else if (rel_cd[b] == '0) begin
          press_cd[b] = '0;
          rel_cd[b] = load_len(rel_db);
        end
      end
    end
    tick_now += 32'd1;
    return f;
  endfunction

  task automatic report(input string field, input logic [3:0] exp_v, input logic [3:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %h, got %h", $time, field, exp_v, got_v);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_flags_t want, got;
    if (!rst_ni) begin
      active_lvl = 4'h0;
      press_db   = 16'd50;
      rel_db     = 16'd50;
      hold_len   = 16'd1000;
      single_len = 16'd300;
      gap_len    = 16'd300;
      last_lvl   = ~active_lvl;
      released   = 4'hF;
      tick_now   = '0;
      for (int b = 0; b < BUTTONS; b++) begin
        press_cd[b]    = '0;
        rel_cd[b]      = '0;
        hold_cd[b]     = '0;
        single_cd[b]   = '0;
        rel_at[b]      = '0;
        prev_rel_at[b] = '0;
      end
      flags_q.delete();
      fails_o   = 0;
      pending_o = 0;
    end else begin
      if (word_valid_i && word_ready_i) begin
        got = word_data_i;
        if (flags_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, got);
          fails_o++;
        end else begin
          want = flags_q.pop_front();
          report("pressed_events", want.prs, got.prs);
          report("released_events", want.rel, got.rel);
          report("single_clicks", want.sgl, got.sgl);
          report("double_clicks", want.dbl, got.dbl);
          report("holds_started", want.hold_start, got.hold_start);
          report("holds_ended", want.hold_end, got.hold_end);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bdc_pkg::CFG_ACTIVE_LEVELS:  active_lvl = cfg_data_i[3:0];
          bdc_pkg::CFG_PRESS_DEBOUNCE: press_db   = cfg_data_i;
          bdc_pkg::CFG_REL_DEBOUNCE:   rel_db     = cfg_data_i;
          bdc_pkg::CFG_HOLD:           hold_len   = cfg_data_i;
          bdc_pkg::CFG_SINGLE_CLICK:   single_len = cfg_data_i;
          bdc_pkg::CFG_DOUBLE_GAP:     gap_len    = cfg_data_i;
          default: ;
        endcase
      end
      if (tick_valid_i && tick_ready_i) flags_q.push_back(classify_tick(tick_data_i[3:0]));
      pending_o = flags_q.size();
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Click classifier testbench
// Feeds pin-level ticks built from press and release runs with bounce noise,
// across several timer settings, with random gaps and a long output stall;
// the scoreboard beside the block checks every result word.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int SQUEEZE_AT   = 350;
  localparam int SQUEEZE_LEN  = 250;

  // Indexes past the last register; writes there must be ignored.
  localparam logic [bdc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [bdc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = '0;   // pin_levels, zero pad
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [23:0]                   m_axis_tdata;        // pressed, released, single,
                                                      // double, hold start, hold end
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [bdc_pkg::DUR_W-1:0]     cfg_data_i = '0;

  int fails;
  int pending;

  bit         calm = 1'b0;
  logic [3:0] cur_active = 4'h0;
  int         cur_press = 50, cur_rel = 50, cur_hold = 1000;
  logic [3:0] pressed_now = 4'h0;
  int         run_left [4] = '{0, 0, 0, 0};

  logic [3:0] boot_ticks [8]  = '{4'hF, 4'h0, 4'hF, 4'h5, 4'hA, 4'h0, 4'hF, 4'hF};
  logic [3:0] short_ticks [17] = '{4'h0, 4'h0, 4'hF, 4'hF, 4'h0, 4'hF, 4'hF, 4'hF,
                                   4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hE,
                                   4'hF};

  button_debounce_click_classifier_unit #(
    .BUTTON_COUNT(4),
    .TIMER_WIDTH (16)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  bdc_checker scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_valid_i(s_axis_tvalid),
    .tick_ready_i(s_axis_tready),
    .tick_data_i (s_axis_tdata),
    .word_valid_i(m_axis_tvalid),
    .word_ready_i(m_axis_tready),
    .word_data_i (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Next pin word: each button alternates pressed and released runs whose
  // lengths straddle the debounce, click and hold windows, with bounce.
  function automatic logic [3:0] next_pins();
    logic [3:0] lv;
    int db, hold_span;
    db = (cur_press > cur_rel) ? cur_press : cur_rel;
    if (db > 200) db = 200;
    hold_span = (cur_hold > 300) ? 300 : cur_hold;
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    for (int b = 0; b < 4; b++) begin
      if (run_left[b] == 0) begin
        pressed_now[b] = ~pressed_now[b];
        case ($urandom_range(0, 3))
          0:       run_left[b] = $urandom_range(1, 2);
          1:       run_left[b] = $urandom_range(1, db + 3);
          2:       run_left[b] = $urandom_range(1, 2 * db + 8);
          default: run_left[b] = $urandom_range(db, db + hold_span + 5);
        endcase
      end
      run_left[b]--;
      lv[b] = pressed_now[b] ? cur_active[b] : ~cur_active[b];
      if ($urandom_range(0, 39) == 0) lv[b] = ~lv[b];
    end
    return lv;
  endfunction

  task automatic send_tick(input logic [3:0] pins);
    int gap, roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, pins};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last write.
  task automatic cfg_write(input logic [bdc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdc_pkg::DUR_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic settle();
    @(negedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [3:0] act, input int pd, input int rd, input int hd,
                           input int sd, input int gd, input int n, input bit quiet);
    settle();
    cfg_write(bdc_pkg::CFG_ACTIVE_LEVELS, {12'b0, act});
    cfg_write(bdc_pkg::CFG_PRESS_DEBOUNCE, 16'(pd));
    cfg_write(bdc_pkg::CFG_REL_DEBOUNCE, 16'(rd));
    cfg_write(bdc_pkg::CFG_HOLD, 16'(hd));
    cfg_write(bdc_pkg::CFG_SINGLE_CLICK, 16'(sd));
    cfg_write(bdc_pkg::CFG_DOUBLE_GAP, 16'(gd));
    cfg_valid_i <= 1'b0;
    cur_active = act;
    cur_press  = pd;
    cur_rel    = rd;
    cur_hold   = hd;
    calm       = quiet;
    repeat (n) send_tick(next_pins());
    s_axis_tvalid <= 1'b0;
  endtask

  // Result side: random back-pressure, plus one long hold-off so the block
  // fills up and stalls its tick input.
  initial begin
    int words, stall_left, roll;
    bit squeezed;
    words = 0;
    stall_left = 0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) words++;
      if (!squeezed && words >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_LEN) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (!calm && roll < 2) begin
          stall_left = $urandom_range(20, 60);
          m_axis_tready <= 1'b0;
        end else if (!calm && roll < 20) begin
          stall_left = $urandom_range(0, 2);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("button_debounce_click_classifier_unit verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: long debounce, so only edges and cancellations happen.
    foreach (boot_ticks[k]) send_tick(boot_ticks[k]);
    s_axis_tvalid <= 1'b0;

    // Zero press debounce acts as one tick; short hold and click windows.
    settle();
    cfg_write(bdc_pkg::CFG_ACTIVE_LEVELS, 16'h0000);
    cfg_write(bdc_pkg::CFG_PRESS_DEBOUNCE, 16'd0);
    cfg_write(bdc_pkg::CFG_REL_DEBOUNCE, 16'd1);
    cfg_write(bdc_pkg::CFG_HOLD, 16'd3);
    cfg_write(bdc_pkg::CFG_SINGLE_CLICK, 16'd2);
    cfg_write(bdc_pkg::CFG_DOUBLE_GAP, 16'd5);
    cfg_write(CFG_SPARE_LO, 16'hFFFF);
    cfg_write(CFG_SPARE_HI, 16'h1234);
    cfg_valid_i <= 1'b0;
    foreach (short_ticks[k]) send_tick(short_ticks[k]);
    s_axis_tvalid <= 1'b0;

    run_phase(4'hF, 2, 3, 10, 8, 12, 130, 1'b0);
    run_phase(4'($urandom_range(0, 15)), 1, 1, 4, 3, 6, 130, 1'b1);
    run_phase(4'h5, 4, 2, 20, 15, 40, 130, 1'b0);
    repeat (2) begin
      run_phase(4'($urandom_range(0, 15)), $urandom_range(1, 6), $urandom_range(1, 6),
                $urandom_range(3, 30), $urandom_range(3, 30), $urandom_range(1, 50),
                130, 1'b0);
    end
    run_phase(4'h0, 1, 1, 1, 1, 65535, 130, 1'b0);
    run_phase(4'hA, 65535, 65535, 65535, 65535, 65535, 40, 1'b1);
    run_phase(4'h0, 50, 50, 1000, 300, 300, 150, 1'b0);
    run_phase(4'h3, 0, 0, 0, 0, 0, 120, 1'b0);

    settle();
    if (fails == 0 && pending == 0) begin
      $display("button_debounce_click_classifier_unit verification clean");
    end else begin
      $display("button_debounce_click_classifier_unit verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bdc_pkg.sv
rtl/core/bdc_state_mem.sv
rtl/core/bdc_button_eval.sv
rtl/core/button_debounce_click_classifier_unit.sv
test/bdc_checker.sv
test/tb.sv
